// ===== rtl/core/rsht_pkg.sv =====
// Package for the range stack height tracker.
// Holds the request and response payload types, the controller state type and the command and status types.
// Depends on nothing.
package rsht_pkg;

	localparam int SPAN_BITS = 10;
	localparam int OUT_HEIGHT_BITS = 20;
	localparam int CFG_BITS = 11;
	localparam logic [CFG_BITS-1:0] COLS_RESET = 11'd1024;
	localparam logic [2:0] ADDR_COLS = 3'd0;

	typedef struct packed {
		logic [SPAN_BITS-1:0] span_left;
		logic [SPAN_BITS-1:0] span_right;
	} req_t;

	typedef struct packed {
		logic [OUT_HEIGHT_BITS-1:0] new_height;
		logic                       span_error;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic load_err;
		logic rd_issue;
		logic ptr_to_left;
		logic wr_en;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic span_bad;
		logic ptr_at_right;
	} sts_t;

endpackage

// ===== rtl/core/rsht_ctrl.sv =====
// Controller of the range stack height tracker.
// Sequences the clearing pass, the read scan and the write scan.
// Depends on rsht_pkg.
module rsht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rsht_pkg::cmd_t  cmd,
	input  rsht_pkg::sts_t  sts
);

	rsht_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic take;

	assign rsp_valid = out_valid_q;
	assign req_stall = (state_q != rsht_pkg::ST_IDLE) || (out_valid_q && rsp_stall);
	assign take = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsht_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = rsht_pkg::ST_IDLE;
			end
			rsht_pkg::ST_IDLE: begin
				if (take && !sts.span_bad) state_d = rsht_pkg::ST_READ;
			end
			rsht_pkg::ST_READ: begin
				if (sts.ptr_at_right) state_d = rsht_pkg::ST_DRAIN;
			end
			rsht_pkg::ST_DRAIN: state_d = rsht_pkg::ST_WRITE;
			rsht_pkg::ST_WRITE: begin
				if (sts.ptr_at_right) state_d = rsht_pkg::ST_IDLE;
			end
			default: state_d = rsht_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rsht_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			rsht_pkg::ST_IDLE: begin
				cmd.accept = take;
				cmd.load_err = take && sts.span_bad;
			end
			rsht_pkg::ST_READ: cmd.rd_issue = 1'b1;
			rsht_pkg::ST_DRAIN: cmd.ptr_to_left = 1'b1;
			rsht_pkg::ST_WRITE: begin
				cmd.wr_en = 1'b1;
				cmd.load_out = sts.ptr_at_right;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsht_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_err || cmd.load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && !rsp_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/rsht_dp.sv =====
// Datapath of the range stack height tracker.
// Holds the height memory, the span pointer, the running maximum and the response.
// Depends on rsht_pkg.
module rsht_dp #(
	parameter int COLUMNS = 1024,
	parameter int HEIGHT_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsht_pkg::req_t              req,
	input  logic [rsht_pkg::CFG_BITS-1:0] cols_in_use,
	input  rsht_pkg::cmd_t              cmd,
	output rsht_pkg::sts_t              sts,
	output rsht_pkg::rsp_t              rsp
);

	localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int SB = rsht_pkg::SPAN_BITS;
	localparam int OB = rsht_pkg::OUT_HEIGHT_BITS;

	logic [HEIGHT_BITS-1:0] mem [COLUMNS];
	logic [HEIGHT_BITS-1:0] rdata_q, top_q, next_h;
	logic [AW-1:0] clr_q, addr;
	logic [SB-1:0] left_q, right_q, ptr_q;
	logic [AW+SB-1:0] ptr_ext;
	logic [OB+HEIGHT_BITS-1:0] h_ext;
	logic rd_vld_q;
	logic [31:0] limit;
	logic we;
	rsht_pkg::rsp_t rsp_q;

	assign limit = ({21'd0, cols_in_use} < 32'(COLUMNS)) ? {21'd0, cols_in_use}
		: 32'(COLUMNS);
	assign sts.span_bad = (req.span_left > req.span_right) ||
		({22'd0, req.span_right} >= limit);
	assign sts.clr_last = (clr_q == AW'(COLUMNS - 1));
	assign sts.ptr_at_right = (ptr_q == right_q);

	assign ptr_ext = {{AW{1'b0}}, ptr_q};
	assign addr = cmd.clr_step ? clr_q : ptr_ext[AW-1:0];
	assign we = cmd.clr_step || cmd.wr_en;
	assign next_h = (top_q == {HEIGHT_BITS{1'b1}}) ? top_q : top_q + 1'b1;
	assign h_ext = {{OB{1'b0}}, next_h};
	assign rsp = rsp_q;

	// Single-port height store; read data is registered.
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= cmd.clr_step ? '0 : next_h;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			rd_vld_q <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			left_q <= req.span_left;
			right_q <= req.span_right;
			ptr_q <= req.span_left;
			top_q <= '0;
		end else begin
			if (cmd.ptr_to_left) ptr_q <= left_q;
			else if ((cmd.rd_issue || cmd.wr_en) && !sts.ptr_at_right) ptr_q <= ptr_q + 1'b1;
			if (rd_vld_q && (rdata_q > top_q)) top_q <= rdata_q;
		end
		if (cmd.load_err) begin
			rsp_q.new_height <= '0;
			rsp_q.span_error <= 1'b1;
		end else if (cmd.load_out) begin
			rsp_q.new_height <= h_ext[OB-1:0];
			rsp_q.span_error <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/range_stack_height_tracker_core.sv =====
// Top level of the range stack height tracker.
// Joins the configuration register, the controller and the datapath.
// Depends on rsht_pkg, rsht_ctrl and rsht_dp.

// The block keeps one height per column, all zero after reset. Each request
// names an inclusive zero-based span; the block finds the largest height in
// the span, adds one (saturating at the top of the height range), writes that
// value to every column of the span and returns it. A reversed span, or one
// whose right end reaches past the smaller of columns_in_use and COLUMNS, is
// answered with span_error set, a height of zero, and no change. After reset
// the block clears its height memory and takes no request meanwhile;
// configuration writes are taken throughout. A good span is answered once
// the single memory port has been walked once to read the span and once to
// write it; a rejected span is answered in the cycle after acceptance.
module range_stack_height_tracker_core #(
	parameter int COLUMNS = 1024,
	parameter int HEIGHT_BITS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            req_valid,
	output logic            req_stall,
	input  rsht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rsht_pkg::rsp_t  rsp
);

	logic [rsht_pkg::CFG_BITS-1:0] cols_q;
	rsht_pkg::cmd_t cmd;
	rsht_pkg::sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr == rsht_pkg::ADDR_COLS) ? {21'd0, cols_q} : 32'd0;

	// The column count register; writes to other addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= rsht_pkg::COLS_RESET;
		end else if (psel && penable && pwrite && (paddr == rsht_pkg::ADDR_COLS)) begin
			cols_q <= pwdata[rsht_pkg::CFG_BITS-1:0];
		end
	end

	rsht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rsht_dp #(
		.COLUMNS     (COLUMNS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cols_in_use (cols_q),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

// ===== rtl/core/rsht_checker.sv =====
// Port checker for the range stack height tracker, with its bind.
// Depends on rsht_pkg and range_stack_height_tracker_core.
module rsht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rsht_pkg::rsp_t rsp
);

	// A held response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A rejected span always reports height zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.span_error |-> rsp.new_height == '0)
		else $error("error response with nonzero height");

	// No new request is taken while a response is blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response blocked");

endmodule

bind range_stack_height_tracker_core rsht_checker u_rsht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== dv/tb.sv =====
// Testbench for range_stack_height_tracker_core: drives random and directed
// column spans, predicts each height from its own copy of the column array.
// Depends on rsht_pkg and the core RTL.
module tb;

	localparam int NCOL = 1024;
	localparam int HMAX = (1 << 20) - 1;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic req_valid, req_stall;
	rsht_pkg::req_t req;
	logic rsp_valid, rsp_stall;
	rsht_pkg::rsp_t rsp;

	range_stack_height_tracker_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Model state: heights per column and the active column count.
	int unsigned col_height [NCOL];
	int unsigned active_cols;

	rsht_pkg::req_t pending_spans [$];
	rsht_pkg::rsp_t expected_heights [$];
	int mismatches;
	int idle_cycles;
	bit hold_off_req;
	int hold_off_left;
	int send_gap;
	int recv_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop one block onto the modeled row and return what the block should answer.
	function automatic rsht_pkg::rsp_t drop_block(rsht_pkg::req_t r);
		rsht_pkg::rsp_t o;
		int unsigned lim;
		int unsigned top;
		int unsigned h;
		lim = (active_cols > NCOL) ? NCOL : active_cols;
		o = '0;
		if (r.span_left > r.span_right || r.span_right >= lim) begin
			o.span_error = 1'b1;
			return o;
		end
		top = 0;
		for (int c = r.span_left; c <= r.span_right; c++)
			if (col_height[c] > top) top = col_height[c];
		h = (top >= HMAX) ? HMAX : top + 1;
		for (int c = r.span_left; c <= r.span_right; c++)
			col_height[c] = h;
		o.new_height = h[19:0];
		return o;
	endfunction

	// Half the time no gap, often short ones, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sender: the request stays up until accepted, then moves on after a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_heights.push_back(drop_block(req));
			end
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_spans.size() > 0) begin
					req_valid <= 1'b1;
					req <= pending_spans.pop_front();
					send_gap <= pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request of the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_gap <= 0;
			hold_off_left <= 0;
		end else begin
			if (hold_off_req && hold_off_left == 0) begin
				hold_off_left <= 300;
				rsp_stall <= 1'b1;
			end else if (hold_off_left > 1) begin
				hold_off_left <= hold_off_left - 1;
			end else if (hold_off_left == 1) begin
				hold_off_left <= 0;
				rsp_stall <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if ($urandom_range(3) == 0) recv_gap <= pick_gap();
			end
		end
	end

	// Checker: each accepted response is matched with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsht_pkg::rsp_t e;
			if (expected_heights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response height=%0d err=%0b",
						rsp.new_height, rsp.span_error);
			end else begin
				e = expected_heights.pop_front();
				if (rsp.new_height !== e.new_height || rsp.span_error !== e.span_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected height=%0d err=%0b, got height=%0d err=%0b",
							e.new_height, e.span_error, rsp.new_height, rsp.span_error);
				end
			end
		end
	end

	// Watchdog over cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Write the column count while idle and mirror it in the model.
	task automatic set_columns(input int unsigned n);
		reg_write(rsht_pkg::ADDR_COLS, n);
		active_cols = n & 32'h7ff;
	endtask

	task automatic add_span(input int l, input int r);
		rsht_pkg::req_t s;
		s.span_left = l[9:0];
		s.span_right = r[9:0];
		pending_spans.push_back(s);
	endtask

	// Wait until every queued span has gone and every response has come back.
	task automatic drain();
		while (pending_spans.size() > 0 || req_valid || expected_heights.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Random spans: mostly narrow, a few wide, some reversed or out of range.
	task automatic random_spans(input int n, input int unsigned lim);
		int l, w, p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 8) begin
				add_span($urandom_range(1023), $urandom_range(1023));
			end else begin
				if (lim == 0) lim = 1;
				w = (p < 90) ? $urandom_range(0, 15) : $urandom_range(0, 300);
				l = $urandom_range(lim - 1);
				if (l + w > int'(lim) - 1) w = int'(lim) - 1 - l;
				add_span(l, l + w);
			end
		end
	endtask

	initial begin
		mismatches = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		for (int c = 0; c < NCOL; c++) col_height[c] = 0;
		active_cols = 1024;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// The height memory is cleared after reset; requests simply wait.

		// Directed: extremes, single columns and reversed spans.
		add_span(0, 0);
		add_span(0, 0);
		add_span(1023, 1023);
		add_span(0, 1023);
		add_span(5, 4);
		add_span(1023, 0);
		add_span(512, 511);
		add_span(341, 682);
		add_span(682, 682);
		add_span(0, 1023);
		drain();

		// Small array: spans at and past the limit.
		set_columns(1);
		add_span(0, 0);
		add_span(0, 1);
		add_span(1, 1);
		drain();

		// A count of zero rejects every span; bits above the count field are dropped.
		set_columns(0);
		add_span(0, 0);
		add_span(10, 20);
		drain();
		set_columns(32'hffff_f800 | 32'd2047);
		add_span(0, 1023);
		add_span(100, 1000);
		drain();

		set_columns(16);
		random_spans(200, 16);
		// The receiver holds off while spans keep coming, so the block backs up.
		hold_off_req = 1'b1;
		repeat (2) @(posedge clk);
		hold_off_req = 1'b0;
		drain();

		set_columns($urandom_range(17, 1023));
		random_spans(250, active_cols);
		drain();

		set_columns(1024);
		random_spans(300, 1024);
		hold_off_req = 1'b1;
		repeat (2) @(posedge clk);
		hold_off_req = 1'b0;
		drain();

		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
